[src/tfr_pkg.sv]
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared format codes, stage payload types and channel widening functions
// for the texel format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

  localparam int unsigned FMT_W = 4;

  localparam logic [FMT_W-1:0] FMT_RGBA8    = 4'd0;
  localparam logic [FMT_W-1:0] FMT_ARGB8    = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGB8     = 4'd2;
  localparam logic [FMT_W-1:0] FMT_ARGB4    = 4'd3;
  localparam logic [FMT_W-1:0] FMT_ARGB1555 = 4'd4;
  localparam logic [FMT_W-1:0] FMT_RGB565   = 4'd5;
  localparam logic [FMT_W-1:0] FMT_LA8      = 4'd6;
  localparam logic [FMT_W-1:0] FMT_L8       = 4'd7;
  localparam logic [FMT_W-1:0] FMT_A8       = 4'd8;

  localparam logic [7:0] CH_FULL = 8'hff;

  // one-hot format select, all zero for undefined codes
  typedef struct packed {
    logic rgba8;
    logic argb8;
    logic rgb8;
    logic argb4;
    logic argb1555;
    logic rgb565;
    logic la8;
    logic l8;
    logic a8;
  } tfr_sel_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } tfr_px_t;

  // after decode
  typedef struct packed {
    tfr_sel_t   sel;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       row_end;
  } tfr_s1_t;

  // after channel expansion
  typedef struct packed {
    tfr_sel_t   sel;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    tfr_px_t    argb4;
    tfr_px_t    argb1555;
    tfr_px_t    rgb565;
    logic       row_end;
  } tfr_s2_t;

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

`default_nettype wire

[src/tfr_in_if.sv]
// ----------------------------------------------------------------------------
// tfr_in_if
// Source pixel channel: four memory-order bytes and a row-end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_zero;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic       row_end_in;

  modport source (
    output valid, byte_zero, byte_one, byte_two, byte_three, row_end_in,
    input  ready
  );

  modport sink (
    input  valid, byte_zero, byte_one, byte_two, byte_three, row_end_in,
    output ready
  );
endinterface

`default_nettype wire

[src/tfr_out_if.sv]
// ----------------------------------------------------------------------------
// tfr_out_if
// Result channel: one packed rgba8888 texel and its row-end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel;
  logic        row_end_out;

  modport source (
    output valid, texel, row_end_out,
    input  ready
  );

  modport sink (
    input  valid, texel, row_end_out,
    output ready
  );
endinterface

`default_nettype wire

[src/texel_format_to_rgba8888_core.sv]
// ----------------------------------------------------------------------------
// texel_format_to_rgba8888_core
// Converts one source pixel per unstalled cycle to an A,B,G,R 8888 texel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the four memory-order bytes of one pixel and a row-end
//   mark; out_ch returns texel (alpha 31:24 .. red 7:0) and the same mark.
//   cfg_we/cfg_wdata set the source format; write it only while no item
//   is in flight. Codes 9 to 15 give a zero texel.
//   An accepted input passes through decode, channel widening and select
//   into the output register. Each of the three stages holds one item, so
//   an item can be taken every cycle while out_ch.ready is high.
//   Synchronous reset clears the stage valid bits and sets the format to
//   RGBA8. When out_ch.ready is low the output register holds its item and
//   empty stages ahead of it still fill; in_ch.ready drops only once all
//   three stages are occupied, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module texel_format_to_rgba8888_core
  import tfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  tfr_in_if.sink                in_ch,
  tfr_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [FMT_W-1:0] cfg_wdata
);

  logic [FMT_W-1:0] fmt_r;
  logic    adv1, adv2, adv3;
  logic    v1, v2, v3;
  tfr_s1_t s1;
  tfr_s2_t s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGBA8;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  // a stage moves when it is empty or the stage after it moves
  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign in_ch.ready = adv1;

  tfr_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv1),
    .vld_in   (in_ch.valid),
    .fmt      (fmt_r),
    .b0       (in_ch.byte_zero),
    .b1       (in_ch.byte_one),
    .b2       (in_ch.byte_two),
    .b3       (in_ch.byte_three),
    .row_end  (in_ch.row_end_in),
    .vld_out  (v1),
    .data_out (s1)
  );

  tfr_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv2),
    .vld_in   (v1),
    .data_in  (s1),
    .vld_out  (v2),
    .data_out (s2)
  );

  tfr_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv3),
    .vld_in  (v2),
    .data_in (s2),
    .vld_out (v3),
    .texel   (out_ch.texel),
    .row_end (out_ch.row_end_out)
  );

  assign out_ch.valid = v3;

endmodule

`default_nettype wire

[src/tfr_decode.sv]
// ----------------------------------------------------------------------------
// tfr_decode
// Stage one: captures the source bytes and decodes the format code into a
// one-hot select.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_decode
  import tfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_in,
  input  wire logic [FMT_W-1:0] fmt,
  input  wire logic [7:0]       b0,
  input  wire logic [7:0]       b1,
  input  wire logic [7:0]       b2,
  input  wire logic [7:0]       b3,
  input  wire logic             row_end,
  output logic                  vld_out,
  output tfr_s1_t               data_out
);

  logic    vld_r;
  tfr_s1_t data_r;
  tfr_s1_t data_nxt;
  tfr_sel_t sel;

  always_comb begin
    sel = '0;
    unique case (fmt)
      FMT_RGBA8:    sel.rgba8    = 1'b1;
      FMT_ARGB8:    sel.argb8    = 1'b1;
      FMT_RGB8:     sel.rgb8     = 1'b1;
      FMT_ARGB4:    sel.argb4    = 1'b1;
      FMT_ARGB1555: sel.argb1555 = 1'b1;
      FMT_RGB565:   sel.rgb565   = 1'b1;
      FMT_LA8:      sel.la8      = 1'b1;
      FMT_L8:       sel.l8       = 1'b1;
      FMT_A8:       sel.a8       = 1'b1;
      default:      sel          = '0;
    endcase
  end

  always_comb begin
    data_nxt.sel     = sel;
    data_nxt.b0      = b0;
    data_nxt.b1      = b1;
    data_nxt.b2      = b2;
    data_nxt.b3      = b3;
    data_nxt.row_end = row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign data_out = data_r;

endmodule

`default_nettype wire

[src/tfr_expand.sv]
// ----------------------------------------------------------------------------
// tfr_expand
// Stage two: widens the narrow channels of the 16-bit formats to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_expand
  import tfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    vld_in,
  input  wire tfr_s1_t data_in,
  output logic         vld_out,
  output tfr_s2_t      data_out
);

  logic        vld_r;
  tfr_s2_t     data_r;
  tfr_s2_t     data_nxt;
  logic [15:0] half;

  // 16-bit formats read the halfword big-endian
  assign half = {data_in.b0, data_in.b1};

  always_comb begin
    data_nxt.sel     = data_in.sel;
    data_nxt.b0      = data_in.b0;
    data_nxt.b1      = data_in.b1;
    data_nxt.b2      = data_in.b2;
    data_nxt.b3      = data_in.b3;
    data_nxt.row_end = data_in.row_end;

    data_nxt.argb4.a = widen4(half[15:12]);
    data_nxt.argb4.r = widen4(half[11:8]);
    data_nxt.argb4.g = widen4(half[7:4]);
    data_nxt.argb4.b = widen4(half[3:0]);

    data_nxt.argb1555.a = half[15] ? CH_FULL : 8'h00;
    data_nxt.argb1555.r = widen5(half[14:10]);
    data_nxt.argb1555.g = widen5(half[9:5]);
    data_nxt.argb1555.b = widen5(half[4:0]);

    data_nxt.rgb565.a = CH_FULL;
    data_nxt.rgb565.r = widen5(half[15:11]);
    data_nxt.rgb565.g = widen6(half[10:5]);
    data_nxt.rgb565.b = widen5(half[4:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign data_out = data_r;

endmodule

`default_nettype wire

[src/tfr_select.sv]
// ----------------------------------------------------------------------------
// tfr_select
// Stage three: picks the channels of the selected format and holds the
// packed texel in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_select
  import tfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    vld_in,
  input  wire tfr_s2_t data_in,
  output logic         vld_out,
  output logic [31:0]  texel,
  output logic         row_end
);

  logic    vld_r;
  tfr_px_t px_r;
  tfr_px_t px_nxt;
  logic    row_end_r;
  tfr_sel_t s;

  assign s = data_in.sel;

  // and-or select; undefined codes leave every select low, giving zero
  always_comb begin
    px_nxt = '0;
    px_nxt = px_nxt | ({32{s.rgba8}} &
             {data_in.b3, data_in.b2, data_in.b1, data_in.b0});
    px_nxt = px_nxt | ({32{s.argb8}} &
             {data_in.b0, data_in.b3, data_in.b2, data_in.b1});
    px_nxt = px_nxt | ({32{s.rgb8}} &
             {CH_FULL, data_in.b2, data_in.b1, data_in.b0});
    px_nxt = px_nxt | ({32{s.argb4}} & data_in.argb4);
    px_nxt = px_nxt | ({32{s.argb1555}} & data_in.argb1555);
    px_nxt = px_nxt | ({32{s.rgb565}} & data_in.rgb565);
    px_nxt = px_nxt | ({32{s.la8}} &
             {data_in.b1, data_in.b0, data_in.b0, data_in.b0});
    px_nxt = px_nxt | ({32{s.l8}} &
             {CH_FULL, data_in.b0, data_in.b0, data_in.b0});
    px_nxt = px_nxt | ({32{s.a8}} &
             {data_in.b0, CH_FULL, CH_FULL, CH_FULL});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r      <= px_nxt;
      row_end_r <= data_in.row_end;
    end
  end

  assign vld_out = vld_r;
  assign texel   = px_r;
  assign row_end = row_end_r;

endmodule

`default_nettype wire
